### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/wnrl_pkg.sv
package wnrl_pkg;

  localparam int WEIGHT_W = 12;
  localparam int ANGLE_W  = 9;
  localparam int DIST_W   = 14;
  localparam int CMD_W    = 16;
  localparam int ADIFF_W  = 9;
  localparam int SPROD_W  = WEIGHT_W + ADIFF_W;
  localparam int DPROD_W  = WEIGHT_W + DIST_W;
  localparam int COST_W   = DPROD_W + 1;

  localparam logic [1:0] KIND_TRACK  = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;

  localparam logic [1:0] CFG_SOUND_W = 2'd0;
  localparam logic [1:0] CFG_OBST_W  = 2'd1;
  localparam logic [1:0] CFG_DIST_W  = 2'd2;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_COMMITTED = 3'd2;
  localparam logic [2:0] ST_MATCH     = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [1:0] {
    OP_TRACK,
    OP_COMMIT,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [CMD_W-1:0]   left_cmd;
    logic signed [CMD_W-1:0]   right_cmd;
    logic signed [ANGLE_W-1:0] sound_angle;
    logic signed [ANGLE_W-1:0] obstacle_angle;
    logic [DIST_W-1:0]         obstacle_distance;
  } cmd_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] sound_weight;
    logic [WEIGHT_W-1:0] obstacle_angle_weight;
    logic [WEIGHT_W-1:0] distance_weight;
  } cfg_t;

endpackage

### rtl/wnrl_front.sv
module wnrl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,  // left_command_in, right_command_in, sound_angle,
                                       // obstacle_angle, obstacle_distance
  input  logic [1:0]        in_tuser,  // kind
  output logic              push_valid,
  input  logic              push_ready,
  output wnrl_pkg::cmd_t    push_cmd
);

  logic           hold_valid_r;
  wnrl_pkg::cmd_t hold_r;
  wnrl_pkg::cmd_t hold_nxt;
  wnrl_pkg::op_t  op;
  logic           in_beat;

  assign in_beat   = in_tvalid && in_tready;
  assign in_tready = !hold_valid_r || push_ready;

  always_comb begin
    unique case (in_tuser)
      wnrl_pkg::KIND_TRACK:  op = wnrl_pkg::OP_TRACK;
      wnrl_pkg::KIND_COMMIT: op = wnrl_pkg::OP_COMMIT;
      default:               op = wnrl_pkg::OP_QUERY;
    endcase
  end

  always_comb begin
    hold_nxt.op                = op;
    hold_nxt.left_cmd          = in_tdata[15:0];
    hold_nxt.right_cmd         = in_tdata[31:16];
    hold_nxt.sound_angle       = in_tdata[40:32];
    hold_nxt.obstacle_angle    = in_tdata[49:41];
    hold_nxt.obstacle_distance = in_tdata[63:50];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_tready) begin
      hold_valid_r <= in_tvalid;
    end
    if (in_beat) begin
      hold_r <= hold_nxt;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_r;

endmodule

### rtl/wnrl_queue.sv
module wnrl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  wnrl_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wnrl_pkg::cmd_t pop_cmd
);

  wnrl_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/wnrl_back.sv
module wnrl_back #(
  parameter int RECORD_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wnrl_pkg::cfg_t                       cfg,
  input  logic                                 cmd_valid,
  output logic                                 cmd_ready,
  input  wnrl_pkg::cmd_t                       cmd,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata,  // left_command_out, right_command_out
  output logic [2:0]                           out_tuser,  // status
  output logic [$clog2(RECORD_DEPTH+1)-1:0]    written_cnt,
  output logic [$clog2(RECORD_DEPTH+1)-1:0]    committed_cnt
);

  localparam int AW = $clog2(RECORD_DEPTH);
  localparam int CW = $clog2(RECORD_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] cmd_mem  [RECORD_DEPTH];
  logic [31:0] feat_mem [RECORD_DEPTH];
  logic [31:0] feat_q_r;
  logic [31:0] cmd_q_r;
  logic        mem_we;

  logic [CW-1:0] written_r, written_nxt;
  logic [CW-1:0] committed_r, committed_nxt;
  logic [AW-1:0] scan_addr_r, scan_addr_nxt;
  logic          scan_last;

  logic signed [wnrl_pkg::ANGLE_W-1:0] q_sound_r, q_obst_r;
  logic [wnrl_pkg::DIST_W-1:0]         q_dist_r;

  logic          v1_r, l1_r;
  logic [AW-1:0] idx1_r;
  logic          v2_r, l2_r;
  logic [AW-1:0] idx2_r;
  logic          v3_r, l3_r;
  logic [AW-1:0] idx3_r;

  logic signed [wnrl_pkg::ANGLE_W:0]  ds_full, do_full;
  logic signed [wnrl_pkg::DIST_W:0]   dd_full;
  logic [wnrl_pkg::ADIFF_W-1:0]       ds_r, do_r;
  logic [wnrl_pkg::DIST_W-1:0]        dd_r;
  logic [wnrl_pkg::SPROD_W-1:0]       ps_r, po_r;
  logic [wnrl_pkg::DPROD_W-1:0]       pd_r;
  logic [wnrl_pkg::COST_W-1:0]        cost;
  logic [wnrl_pkg::COST_W-1:0]        best_cost_r, best_cost_nxt;
  logic [AW-1:0]                      best_idx_r, best_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        slot_free;
  logic        pop;
  logic        full;

  assign slot_free = !out_valid_r || out_tready;
  assign pop       = cmd_valid && (state_r == S_IDLE) && slot_free;
  assign cmd_ready = pop;
  assign full      = (written_r == CW'(RECORD_DEPTH));
  assign mem_we    = pop && (cmd.op == wnrl_pkg::OP_TRACK) && !full;
  assign scan_last = (CW'(scan_addr_r) == (committed_r - CW'(1)));

  // distance stage: absolute feature differences against the query
  always_comb begin
    ds_full = $signed({q_sound_r[wnrl_pkg::ANGLE_W-1], q_sound_r})
            - $signed({feat_q_r[8], feat_q_r[8:0]});
    do_full = $signed({q_obst_r[wnrl_pkg::ANGLE_W-1], q_obst_r})
            - $signed({feat_q_r[17], feat_q_r[17:9]});
    dd_full = $signed({1'b0, q_dist_r}) - $signed({1'b0, feat_q_r[31:18]});
  end

  assign cost = wnrl_pkg::COST_W'(ps_r) + wnrl_pkg::COST_W'(po_r)
              + wnrl_pkg::COST_W'(pd_r);

  // keep the first record on ties
  always_comb begin
    best_cost_nxt = best_cost_r;
    best_idx_nxt  = best_idx_r;
    if (v3_r && ((idx3_r == '0) || (cost < best_cost_r))) begin
      best_cost_nxt = cost;
      best_idx_nxt  = idx3_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    written_nxt    = written_r;
    committed_nxt  = committed_r;
    scan_addr_nxt  = scan_addr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          out_data_nxt = '0;
          unique case (cmd.op)
            wnrl_pkg::OP_TRACK: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = wnrl_pkg::ST_FULL;
              end else begin
                out_status_nxt = wnrl_pkg::ST_STORED;
                written_nxt    = written_r + CW'(1);
              end
            end
            wnrl_pkg::OP_COMMIT: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = wnrl_pkg::ST_COMMITTED;
              committed_nxt  = written_r;
            end
            default: begin
              if (committed_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = wnrl_pkg::ST_EMPTY;
              end else begin
                scan_addr_nxt = '0;
                state_nxt     = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_addr_nxt = scan_addr_r + AW'(1);
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (v3_r && l3_r) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = wnrl_pkg::ST_MATCH;
        out_data_nxt   = cmd_q_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cmd_mem[written_r[AW-1:0]]  <= {cmd.right_cmd, cmd.left_cmd};
      feat_mem[written_r[AW-1:0]] <= {cmd.obstacle_distance, cmd.obstacle_angle,
                                      cmd.sound_angle};
    end
    feat_q_r <= feat_mem[scan_addr_r];
    cmd_q_r  <= cmd_mem[best_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      written_r   <= '0;
      committed_r <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      written_r   <= written_nxt;
      committed_r <= committed_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= (state_r == S_SCAN);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r  <= scan_addr_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    best_cost_r  <= best_cost_nxt;
    best_idx_r   <= best_idx_nxt;
    if (pop) begin
      q_sound_r <= cmd.sound_angle;
      q_obst_r  <= cmd.obstacle_angle;
      q_dist_r  <= cmd.obstacle_distance;
    end
    l1_r   <= scan_last;
    idx1_r <= scan_addr_r;
    l2_r   <= l1_r;
    idx2_r <= idx1_r;
    ds_r   <= ds_full[wnrl_pkg::ANGLE_W] ? wnrl_pkg::ADIFF_W'(-ds_full)
                                         : wnrl_pkg::ADIFF_W'(ds_full);
    do_r   <= do_full[wnrl_pkg::ANGLE_W] ? wnrl_pkg::ADIFF_W'(-do_full)
                                         : wnrl_pkg::ADIFF_W'(do_full);
    dd_r   <= dd_full[wnrl_pkg::DIST_W] ? wnrl_pkg::DIST_W'(-dd_full)
                                        : wnrl_pkg::DIST_W'(dd_full);
    l3_r   <= l2_r;
    idx3_r <= idx2_r;
    ps_r   <= wnrl_pkg::SPROD_W'(cfg.sound_weight) * wnrl_pkg::SPROD_W'(ds_r);
    po_r   <= wnrl_pkg::SPROD_W'(cfg.obstacle_angle_weight) * wnrl_pkg::SPROD_W'(do_r);
    pd_r   <= wnrl_pkg::DPROD_W'(cfg.distance_weight) * wnrl_pkg::DPROD_W'(dd_r);
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_status_r;
  assign written_cnt   = written_r;
  assign committed_cnt = committed_r;

endmodule

### rtl/weighted_nearest_record_lookup.sv
// Record store with weighted-L1 nearest lookup. Each input beat carries a kind in
// in_tuser: track appends a record, commit makes all tracked records searchable,
// query returns the commands of the committed record with the least weighted sum
// of absolute feature differences, the earliest record winning ties. One result
// beat answers each input beat, status in out_tuser. A front register, a
// two-entry queue and the execution engine sit in series, so input beats keep
// flowing while the engine is busy, until the queue fills. A query reads the
// feature memory one record per cycle into a three-stage cost pipeline, then
// does one command memory read. Records hold their contents only once written;
// no clearing pass runs after reset. Write weights only while no beat is in
// flight.
`include "assert_macros.svh"

module weighted_nearest_record_lookup #(
  parameter int RECORD_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // left_command_in, right_command_in, sound_angle,
                                  // obstacle_angle, obstacle_distance
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // left_command_out, right_command_out
  output logic [2:0]  out_tuser   // status
);

  localparam int CW = $clog2(RECORD_DEPTH + 1);

  wnrl_pkg::cfg_t cfg_r;
  logic           push_valid, push_ready;
  wnrl_pkg::cmd_t push_cmd;
  logic           pop_valid, pop_ready;
  wnrl_pkg::cmd_t pop_cmd;
  logic [CW-1:0]  written_cnt, committed_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sound_weight          <= 12'd1000;
      cfg_r.obstacle_angle_weight <= 12'd1000;
      cfg_r.distance_weight       <= 12'd36;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wnrl_pkg::CFG_SOUND_W: cfg_r.sound_weight          <= cfg_wdata;
        wnrl_pkg::CFG_OBST_W:  cfg_r.obstacle_angle_weight <= cfg_wdata;
        wnrl_pkg::CFG_DIST_W:  cfg_r.distance_weight       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wnrl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  wnrl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  wnrl_back #(
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cmd_valid     (pop_valid),
    .cmd_ready     (pop_ready),
    .cmd           (pop_cmd),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .written_cnt   (written_cnt),
    .committed_cnt (committed_cnt)
  );

  `ASSERT_IMPLY(a_cmd_zero_unless_match, clk, rst_n, out_tvalid && (out_tuser != wnrl_pkg::ST_MATCH), out_tdata == '0)
  `ASSERT_IMPLY(a_commit_within_written, clk, rst_n, 1'b1, committed_cnt <= written_cnt)
  `ASSERT_IMPLY(a_written_within_depth, clk, rst_n, 1'b1, written_cnt <= CW'(RECORD_DEPTH))

endmodule

### dv/weighted_nearest_record_lookup_tb.sv
`timescale 1ns / 1ps

module weighted_nearest_record_lookup_tb;

  localparam int RECORD_DEPTH = 256;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 800;
  localparam int MAX_PRINTS = 100;
  localparam int RANDOM_WEIGHT = -1;
  localparam logic [1:0] KIND_TRACK = wnrl_pkg::KIND_TRACK;
  localparam logic [1:0] KIND_COMMIT = wnrl_pkg::KIND_COMMIT;
  localparam logic [1:0] KIND_QUERY = wnrl_pkg::OP_QUERY;
  localparam logic [1:0] KIND_QUERY_ALT = 2'd3;
  localparam logic [2:0] ST_STORED = wnrl_pkg::ST_STORED;
  localparam logic [2:0] ST_FULL = wnrl_pkg::ST_FULL;
  localparam logic [2:0] ST_COMMITTED = wnrl_pkg::ST_COMMITTED;
  localparam logic [2:0] ST_MATCH = wnrl_pkg::ST_MATCH;
  localparam logic [2:0] ST_EMPTY = wnrl_pkg::ST_EMPTY;
  localparam logic [1:0] CFG_SOUND_W = wnrl_pkg::CFG_SOUND_W;
  localparam logic [1:0] CFG_OBST_W = wnrl_pkg::CFG_OBST_W;
  localparam logic [1:0] CFG_DIST_W = wnrl_pkg::CFG_DIST_W;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] l;
    logic [15:0] r;
    logic [8:0]  snd;
    logic [8:0]  obs;
    logic [13:0] odist;
  } beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] l_out;
    logic [15:0] r_out;
  } answer_t;

  typedef struct packed {
    beat_t   b;
    bit      typed;
    answer_t a;
  } script_row_t;

  localparam answer_t NO_ANSWER = '{ST_STORED, 16'h0000, 16'h0000};

  localparam script_row_t SCRIPT [21] = '{
    '{'{KIND_QUERY, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_EMPTY, 16'h0, 16'h0}},
    '{'{KIND_COMMIT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_COMMITTED, 16'h0, 16'h0}},
    '{'{KIND_QUERY_ALT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_EMPTY, 16'h0, 16'h0}},
    '{'{KIND_TRACK, 16'h8000, 16'h7fff, -9'sd180, 9'sd180, 14'd0}, 1'b1,
      '{ST_STORED, 16'h0, 16'h0}},
    '{'{KIND_QUERY, 16'h0, 16'h0, -9'sd180, 9'sd180, 14'd0}, 1'b1, '{ST_EMPTY, 16'h0, 16'h0}},
    '{'{KIND_COMMIT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_COMMITTED, 16'h0, 16'h0}},
    '{'{KIND_QUERY, 16'h0, 16'h0, 9'sd180, -9'sd180, 14'd10000}, 1'b1,
      '{ST_MATCH, 16'h8000, 16'h7fff}},
    '{'{KIND_TRACK, 16'h7fff, 16'h8000, 9'sd180, -9'sd180, 14'd10000}, 1'b1,
      '{ST_STORED, 16'h0, 16'h0}},
    '{'{KIND_TRACK, 16'h1234, 16'hfedc, 9'sd0, 9'sd0, 14'd5000}, 1'b1,
      '{ST_STORED, 16'h0, 16'h0}},
    '{'{KIND_COMMIT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_COMMITTED, 16'h0, 16'h0}},
    '{'{KIND_QUERY, 16'h0, 16'h0, 9'sd170, -9'sd170, 14'd9000}, 1'b0, NO_ANSWER},
    '{'{KIND_QUERY, 16'h0, 16'h0, -9'sd180, 9'sd180, 14'd0}, 1'b0, NO_ANSWER},
    '{'{KIND_TRACK, 16'h4000, 16'hc000, -9'sd180, 9'sd180, 14'd0}, 1'b1,
      '{ST_STORED, 16'h0, 16'h0}},
    '{'{KIND_COMMIT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_COMMITTED, 16'h0, 16'h0}},
    '{'{KIND_QUERY, 16'h0, 16'h0, -9'sd180, 9'sd180, 14'd0}, 1'b1,
      '{ST_MATCH, 16'h8000, 16'h7fff}},
    '{'{KIND_QUERY, 16'h0, 16'h0, 9'h0ff, 9'h100, 14'h3fff}, 1'b0, NO_ANSWER},
    '{'{KIND_COMMIT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_COMMITTED, 16'h0, 16'h0}},
    '{'{KIND_QUERY_ALT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd5000}, 1'b0, NO_ANSWER},
    '{'{KIND_TRACK, 16'hffff, 16'h0000, 9'h1ff, 9'h0ff, 14'h2aaa}, 1'b1,
      '{ST_STORED, 16'h0, 16'h0}},
    '{'{KIND_COMMIT, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b1, '{ST_COMMITTED, 16'h0, 16'h0}},
    '{'{KIND_QUERY, 16'h0, 16'h0, 9'sd0, 9'sd0, 14'd0}, 1'b0, NO_ANSWER}
  };

  localparam int PHASE_WEIGHTS [PHASE_COUNT][3] = '{
    '{0, 0, 0},
    '{4095, 4095, 4095},
    '{4095, 0, 1},
    '{RANDOM_WEIGHT, RANDOM_WEIGHT, RANDOM_WEIGHT},
    '{0, 4095, 0},
    '{1, 1, 4095},
    '{RANDOM_WEIGHT, RANDOM_WEIGHT, RANDOM_WEIGHT},
    '{1000, 1000, 36}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_SOUND_W;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // left_command_in, right_command_in, sound_angle,
                                // obstacle_angle, obstacle_distance
  logic [1:0]  in_tuser = '0;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // left_command_out, right_command_out
  logic [2:0]  out_tuser;       // status

  beat_t       rec [RECORD_DEPTH];
  int          rec_written = 0;
  int          rec_committed = 0;
  logic [11:0] w_sound = 12'd1000;
  logic [11:0] w_obst = 12'd1000;
  logic [11:0] w_dist = 12'd36;

  answer_t     answers_due [$];
  int          answers_seen = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic        quiet;

  assign quiet = ((cycle_count / 3000) % 5) == 2;

  weighted_nearest_record_lookup #(
    .RECORD_DEPTH(RECORD_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint abs_gap(int a, int b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic answer_t apply_item(beat_t b);
    answer_t a;
    longint  cost;
    longint  best_cost;
    int      best;
    a = NO_ANSWER;
    best_cost = 0;
    best = 0;
    case (b.kind)
      KIND_TRACK: begin
        if (rec_written >= RECORD_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          rec[rec_written] = b;
          rec_written++;
          a.status = ST_STORED;
        end
      end
      KIND_COMMIT: begin
        rec_committed = rec_written;
        a.status = ST_COMMITTED;
      end
      default: begin
        if (rec_committed == 0) begin
          a.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < rec_committed; i++) begin
            cost = longint'(w_sound)
                     * abs_gap(int'($signed(b.snd)), int'($signed(rec[i].snd)))
                 + longint'(w_obst)
                     * abs_gap(int'($signed(b.obs)), int'($signed(rec[i].obs)))
                 + longint'(w_dist) * abs_gap(int'(b.odist), int'(rec[i].odist));
            if (i == 0 || cost < best_cost) begin
              best_cost = cost;
              best = i;
            end
          end
          a.status = ST_MATCH;
          a.l_out = rec[best].l;
          a.r_out = rec[best].r;
        end
      end
    endcase
    return a;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    int    r;
    int    m;
    int    idx;
    r = $urandom_range(0, 99);
    m = $urandom_range(0, 9);
    b.l = 16'($urandom);
    b.r = 16'($urandom);
    if ($urandom_range(0, 9) == 0) b.l = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    if ($urandom_range(0, 9) == 0) b.r = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    b.snd = 9'($urandom_range(0, 360) - 180);
    b.obs = 9'($urandom_range(0, 360) - 180);
    b.odist = 14'($urandom_range(0, 10000));
    if (r < 20) begin
      b.kind = KIND_TRACK;
      if (m < 2 && rec_written > 0) begin
        idx = $urandom_range(0, rec_written - 1);
        b.snd = rec[idx].snd;
        b.obs = rec[idx].obs;
        b.odist = rec[idx].odist;
      end else if (m == 2) begin
        b.snd = 9'($urandom);
        b.obs = 9'($urandom);
        b.odist = 14'($urandom);
      end
    end else if (r < 30) begin
      b.kind = KIND_COMMIT;
    end else begin
      b.kind = (r < 34) ? KIND_QUERY_ALT : KIND_QUERY;
      if (m < 7 && rec_committed > 0) begin
        idx = $urandom_range(0, rec_committed - 1);
        b.snd = rec[idx].snd;
        b.obs = rec[idx].obs;
        b.odist = rec[idx].odist;
        if (m >= 4) begin
          b.snd = b.snd + 9'($urandom_range(0, 8)) - 9'd4;
          b.obs = b.obs + 9'($urandom_range(0, 8)) - 9'd4;
          b.odist = b.odist + 14'($urandom_range(0, 200)) - 14'd100;
        end
      end else if (m == 7) begin
        b.snd = 9'($urandom);
        b.obs = 9'($urandom);
        b.odist = 14'($urandom);
      end
    end
    return b;
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input answer_t typed_ans);
    answer_t a;
    int      gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= b.kind;
    in_tdata <= {b.odist, b.obs, b.snd, b.r, b.l};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    a = apply_item(b);
    answers_due.insert(answers_due.size(), typed ? typed_ans : a);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch on result beat %0d: %s got %h want %h",
               answers_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && answers_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      out_tready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      answers_seen <= answers_seen + 1;
      if (answers_due.size() == 0) begin
        report_mismatch("result beat with nothing pending", {29'b0, out_tuser}, '0);
      end else begin
        want = answers_due.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", {29'b0, out_tuser}, {29'b0, want.status});
        if (out_tdata[15:0] !== want.l_out)
          report_mismatch("left_command_out", {16'b0, out_tdata[15:0]}, {16'b0, want.l_out});
        if (out_tdata[31:16] !== want.r_out)
          report_mismatch("right_command_out", {16'b0, out_tdata[31:16]},
                          {16'b0, want.r_out});
      end
    end
  end

  initial begin
    logic [11:0] w [3];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (SCRIPT[k]) send_beat(SCRIPT[k].b, SCRIPT[k].typed, SCRIPT[k].a);
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      in_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
      for (int j = 0; j < 3; j++)
        w[j] = (PHASE_WEIGHTS[ph][j] == RANDOM_WEIGHT) ? 12'($urandom_range(0, 4095))
                                                       : 12'(PHASE_WEIGHTS[ph][j]);
      cfg_we <= 1'b1;
      cfg_addr <= CFG_SOUND_W;
      cfg_wdata <= w[0];
      @(posedge clk);
      cfg_addr <= CFG_OBST_W;
      cfg_wdata <= w[1];
      @(posedge clk);
      cfg_addr <= CFG_DIST_W;
      cfg_wdata <= w[2];
      @(posedge clk);
      cfg_we <= 1'b0;
      w_sound = w[0];
      w_obst = w[1];
      w_dist = w[2];
      repeat (PHASE_ITEMS) send_beat(random_beat(), 1'b0, NO_ANSWER);
    end
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
